// ----- hw/rtl/ujes_pkg.sv -----
// ----------------------------------------------------------------------------
// ujes_pkg
// Shared types and constants for the UTF-8 to JSON escaped stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package ujes_pkg;

   // utf-16 code units that show up in \uXXXX escapes, and the supplementary plane base
   localparam logic [15:0] UNIT_REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] UNIT_HIGH_BASE   = 16'hD800;
   localparam logic [15:0] UNIT_LOW_BASE    = 16'hDC00;
   localparam logic [20:0] SUPP_PLANE_BASE  = 21'h10000;

   // ascii characters used by the escaper
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;

   // output plan of one item: up to four \uXXXX escapes, then up to three raw bytes
   typedef struct packed {
      logic [3:0][15:0] units;
      logic [2:0]       n_units;
      logic [2:0][7:0]  raw;
      logic [1:0]       n_raw;
      logic             last;
   } plan_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ujes_req_if.sv -----
// ----------------------------------------------------------------------------
// ujes_req_if
// Input channel: one raw UTF-8 byte per item plus end-of-string flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ujes_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ujes_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ujes_rsp_if
// Result channel: one byte of the escaped string per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ujes_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       string_end;

   modport source (output valid, output out_byte, output run_end, output string_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input string_end,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ujes_frontend.sv -----
// ----------------------------------------------------------------------------
// ujes_frontend
// UTF-8 sequence tracker: holds partial sequences and turns each input byte
// into an output plan of escapes and raw bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ujes_frontend import ujes_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_take,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output plan_type        plan,
   output logic            plan_has_output
);

   logic [7:0] held_bytes_ff [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] expected_length_ff, expected_length_in;
   logic [2:0] held_wr_en;

   always_comb begin
      logic [7:0]  cont_lo;
      logic [7:0]  cont_hi;
      logic        cont_ok;
      logic [2:0]  lead_len;
      logic [7:0]  esc_char;
      logic        do_fresh;
      logic [1:0]  n_pre;
      logic [1:0]  n_body;
      logic [1:0]  n_post;
      logic [15:0] body_unit0;
      logic [15:0] body_unit1;
      logic [20:0] scalar_value;
      logic [20:0] offset;
      logic [2:0]  rel;

      // second byte of a sequence has a narrowed range for some leads
      cont_lo = 8'h80;
      cont_hi = 8'hBF;
      if (held_count_ff == 2'd1) begin
         case (held_bytes_ff[0])
            8'hE0:   cont_lo = 8'hA0;
            8'hED:   cont_hi = 8'h9F;
            8'hF0:   cont_lo = 8'h90;
            8'hF4:   cont_hi = 8'h8F;
            default: ;
         endcase
      end
      cont_ok = (held_count_ff != 2'd0) && ({1'b0, held_count_ff} < expected_length_ff)
                && (expected_length_ff <= 3'd4)
                && (in_byte >= cont_lo) && (in_byte <= cont_hi);

      case (in_byte) inside
         [8'hC2:8'hDF]: lead_len = 3'd2;
         [8'hE0:8'hEF]: lead_len = 3'd3;
         [8'hF0:8'hF4]: lead_len = 3'd4;
         default:       lead_len = 3'd0;
      endcase

      case (in_byte)
         CHAR_QUOTE:     esc_char = CHAR_QUOTE;
         CHAR_BACKSLASH: esc_char = CHAR_BACKSLASH;
         8'h08:          esc_char = CHAR_LOWER_B;
         8'h09:          esc_char = CHAR_LOWER_T;
         8'h0A:          esc_char = CHAR_LOWER_N;
         8'h0C:          esc_char = CHAR_LOWER_F;
         8'h0D:          esc_char = CHAR_LOWER_R;
         default:        esc_char = 8'h00;
      endcase

      scalar_value = {held_bytes_ff[0][2:0], held_bytes_ff[1][5:0],
                      held_bytes_ff[2][5:0], in_byte[5:0]};
      offset       = scalar_value - SUPP_PLANE_BASE;

      do_fresh           = 1'b0;
      n_pre              = 2'd0;
      n_body             = 2'd0;
      body_unit0         = UNIT_REPLACEMENT;
      body_unit1         = UNIT_REPLACEMENT;
      plan.raw           = '0;
      plan.n_raw         = 2'd0;
      held_wr_en         = 3'b000;
      held_count_in      = held_count_ff;
      expected_length_in = expected_length_ff;

      if (cont_ok) begin
         if ({1'b0, held_count_ff} + 3'd1 == expected_length_ff) begin
            if (expected_length_ff == 3'd4) begin
               // supplementary plane: surrogate pair
               n_body     = 2'd2;
               body_unit0 = UNIT_HIGH_BASE + {6'd0, offset[19:10]};
               body_unit1 = UNIT_LOW_BASE + {6'd0, offset[9:0]};
            end else begin
               plan.raw[0] = held_bytes_ff[0];
               plan.raw[1] = (held_count_ff == 2'd1) ? in_byte : held_bytes_ff[1];
               plan.raw[2] = in_byte;
               plan.n_raw  = held_count_ff + 2'd1;
            end
            held_count_in      = 2'd0;
            expected_length_in = 3'd0;
         end else begin
            held_wr_en[held_count_ff] = 1'b1;
            held_count_in             = held_count_ff + 2'd1;
         end
      end else begin
         // broken or no sequence: flush what is held, then start over
         n_pre              = held_count_ff;
         held_count_in      = 2'd0;
         expected_length_in = 3'd0;
         do_fresh           = 1'b1;
      end

      if (do_fresh) begin
         if (!in_byte[7]) begin
            if (esc_char != 8'h00) begin
               plan.raw[0] = CHAR_BACKSLASH;
               plan.raw[1] = esc_char;
               plan.n_raw  = 2'd2;
            end else if (in_byte < 8'h20) begin
               n_body     = 2'd1;
               body_unit0 = {8'h00, in_byte};
            end else begin
               plan.raw[0] = in_byte;
               plan.n_raw  = 2'd1;
            end
         end else if (lead_len == 3'd0) begin
            n_body     = 2'd1;
            body_unit0 = UNIT_REPLACEMENT;
         end else begin
            held_wr_en[0]      = 1'b1;
            held_count_in      = 2'd1;
            expected_length_in = lead_len;
         end
      end

      // end of string flushes a still open sequence
      n_post = 2'd0;
      if (in_last) begin
         n_post             = held_count_in;
         held_count_in      = 2'd0;
         expected_length_in = 3'd0;
      end

      plan.n_units = {1'b0, n_pre} + {1'b0, n_body} + {1'b0, n_post};
      for (int i = 0; i < 4; i++) begin
         rel = 3'(i) - {1'b0, n_pre};
         if ((3'(i) >= {1'b0, n_pre}) && (rel < {1'b0, n_body}))
            plan.units[i] = rel[0] ? body_unit1 : body_unit0;
         else
            plan.units[i] = UNIT_REPLACEMENT;
      end
      plan.last       = in_last;
      plan_has_output = (plan.n_units != 3'd0) || (plan.n_raw != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff      <= 2'd0;
         expected_length_ff <= 3'd0;
      end else if (item_take) begin
         held_count_ff      <= held_count_in;
         expected_length_ff <= expected_length_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (item_take && held_wr_en[i]) held_bytes_ff[i] <= in_byte;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ujes_serializer.sv -----
// ----------------------------------------------------------------------------
// ujes_serializer
// Plan register and byte sequencer: walks one output plan a byte per cycle
// into the result register while the result side does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ujes_serializer import ujes_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       plan_load,
   input  plan_type        plan_new,
   output logic            take_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      out_byte,
   output logic            run_end,
   output logic            string_end
);

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return CHAR_ZERO + {4'd0, v};
      else           return CHAR_UPPER_A + {4'd0, v} - 8'd10;
   endfunction

   plan_type   plan_ff;
   logic       plan_valid_ff, plan_valid_in;
   logic [2:0] unit_idx_ff, unit_idx_in;
   logic [2:0] char_idx_ff, char_idx_in;
   logic [1:0] raw_idx_ff, raw_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       run_end_ff, string_end_ff;

   logic        out_load;
   logic        emit;
   logic        in_units;
   logic        is_final;
   logic [15:0] unit_sel;
   logic [7:0]  cur_byte;

   always_comb begin
      out_load = !rsp_valid_ff || rsp_ready;
      emit     = plan_valid_ff && out_load;
      in_units = unit_idx_ff < plan_ff.n_units;
      unit_sel = plan_ff.units[unit_idx_ff[1:0]];

      if (in_units) begin
         case (char_idx_ff)
            3'd0:    cur_byte = CHAR_BACKSLASH;
            3'd1:    cur_byte = CHAR_LOWER_U;
            3'd2:    cur_byte = hex_char(unit_sel[15:12]);
            3'd3:    cur_byte = hex_char(unit_sel[11:8]);
            3'd4:    cur_byte = hex_char(unit_sel[7:4]);
            default: cur_byte = hex_char(unit_sel[3:0]);
         endcase
         is_final = (plan_ff.n_raw == 2'd0) && (char_idx_ff == 3'd5)
                    && (unit_idx_ff == plan_ff.n_units - 3'd1);
      end else begin
         case (raw_idx_ff)
            2'd0:    cur_byte = plan_ff.raw[0];
            2'd1:    cur_byte = plan_ff.raw[1];
            default: cur_byte = plan_ff.raw[2];
         endcase
         is_final = raw_idx_ff == plan_ff.n_raw - 2'd1;
      end

      take_ready = !plan_valid_ff || (emit && is_final);

      plan_valid_in = plan_valid_ff;
      unit_idx_in   = unit_idx_ff;
      char_idx_in   = char_idx_ff;
      raw_idx_in    = raw_idx_ff;
      if (emit) begin
         if (is_final) plan_valid_in = 1'b0;
         if (in_units) begin
            if (char_idx_ff == 3'd5) begin
               char_idx_in = 3'd0;
               unit_idx_in = unit_idx_ff + 3'd1;
            end else begin
               char_idx_in = char_idx_ff + 3'd1;
            end
         end else begin
            raw_idx_in = raw_idx_ff + 2'd1;
         end
      end
      if (plan_load) begin
         plan_valid_in = 1'b1;
         unit_idx_in   = 3'd0;
         char_idx_in   = 3'd0;
         raw_idx_in    = 2'd0;
      end

      rsp_valid_in = out_load ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         unit_idx_ff   <= 3'd0;
         char_idx_ff   <= 3'd0;
         raw_idx_ff    <= 2'd0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         unit_idx_ff   <= unit_idx_in;
         char_idx_ff   <= char_idx_in;
         raw_idx_ff    <= raw_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plan_load) plan_ff <= plan_new;
      if (emit) begin
         out_byte_ff   <= cur_byte;
         run_end_ff    <= is_final;
         string_end_ff <= is_final && plan_ff.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign out_byte   = out_byte_ff;
   assign run_end    = run_end_ff;
   assign string_end = string_end_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_to_json_escaped_stream_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_json_escaped_stream_core
// Streaming JSON string escaper: UTF-8 bytes in, escaped string bytes out.
// ----------------------------------------------------------------------------
//
//   channel    direction  payload                          per item
//   req_chan   in         in_byte[7:0], in_last            one raw UTF-8 byte
//   rsp_chan   out        out_byte[7:0], run_end,          one escaped byte
//                         string_end
//
// an accepted byte is decoded in the same cycle into an output plan that lands
// in the plan register; the sequencer then moves one byte a cycle into the
// result register while not stalled, so a result passes the plan register, then the result register
// an item causing n result bytes (0 to 24) keeps the sequencer busy until all n have moved;
// req_ready rises again in the cycle its last byte moves out, so one-byte items
// flow at one item per cycle when not stalled, and bytes that only extend a held
// sequence cost nothing on the result side
// rsp_ready low stalls the result register, the sequencer and then req_ready
// reset clears held count, plan valid and result valid; held bytes keep
// whatever they had, as they are only read below the held count
//
`default_nettype none

module utf8_to_json_escaped_stream_core import ujes_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ujes_req_if.sink  req_chan,
   ujes_rsp_if.source rsp_chan
);

   // flat copies of the channel signals
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_end;
   logic       rsp_string_end;

   // handoff between tracker and sequencer
   plan_type plan;
   logic     plan_has_output;
   logic     take_ready;
   logic     item_take;

   assign req_valid   = req_chan.valid;
   assign req_in_byte = req_chan.in_byte;
   assign req_in_last = req_chan.in_last;
   assign req_chan.ready = req_ready;

   assign rsp_ready           = rsp_chan.ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.out_byte   = rsp_out_byte;
   assign rsp_chan.run_end    = rsp_run_end;
   assign rsp_chan.string_end = rsp_string_end;

   // an item is taken only when the sequencer can start its plan
   assign req_ready = take_ready;
   assign item_take = req_valid && req_ready;

   // sequence tracking and per-byte decode
   ujes_frontend u_frontend (
      .clock           (clock),
      .reset           (reset),
      .item_take       (item_take),
      .in_byte         (req_in_byte),
      .in_last         (req_in_last),
      .plan            (plan),
      .plan_has_output (plan_has_output)
   );

   // items that only extend a held sequence load no plan
   ujes_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .plan_load  (item_take && plan_has_output),
      .plan_new   (plan),
      .take_ready (take_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .out_byte   (rsp_out_byte),
      .run_end    (rsp_run_end),
      .string_end (rsp_string_end)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/ujes_checker.sv -----
// ----------------------------------------------------------------------------
// ujes_checker
// Port-level checks for the escaped stream core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ujes_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_run_end,
   input wire logic       rsp_string_end
);

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_out_byte) && $stable(rsp_run_end)
                                     && $stable(rsp_string_end)))
      else $error("result payload changed while stalled");

   // string end only on the final byte of an input item
   a_string_end_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_end)
      else $error("string_end without run_end");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind utf8_to_json_escaped_stream_core ujes_checker u_ujes_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_run_end    (rsp_run_end),
   .rsp_string_end (rsp_string_end)
);

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_json_escaped_stream_core. A short directed
// table comes first: control bytes, escapes, bad leads, surrogate pairs and
// broken or truncated sequences. Random strings follow, mostly well-formed
// UTF-8 with some broken content. Every escaped byte is checked in order
// against an in-bench escaper model or a directed row's expected bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // one escaped output byte as the block reports it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } esc_result_type;

   // directed row: empty want means the escaper model supplies the bytes
   typedef struct {
      logic [7:0] in_byte;
      logic       in_last;
      string      want;
   } dir_row_type;

   localparam int N_DIRECTED   = 25;
   localparam int N_RANDOM     = 425;
   localparam int SETTLE_TICKS = 40;

   localparam logic [7:0]  CH_BSLASH = 8'h5C;
   localparam logic [7:0]  CH_QUOTE  = 8'h22;
   localparam logic [7:0]  CH_U      = 8'h75;
   localparam logic [15:0] UNIT_BAD  = 16'hFFFD;

   // character classes for the random strings
   typedef enum int {
      PICK_ASCII, PICK_TWO, PICK_THREE, PICK_FOUR,
      PICK_NOISE, PICK_TRUNC, PICK_BREAK, PICK_EDGE
   } pick_type;

   logic clock;
   logic reset;

   ujes_req_if req_chan ();
   ujes_rsp_if rsp_chan ();

   utf8_to_json_escaped_stream_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // escaper model state
   logic [7:0] held_b [0:2];
   int         held_n;
   int         seq_len;
   logic [7:0] esc_bytes [$];

   esc_result_type escaped_q [$];
   logic [7:0]     str_bytes [$];
   dir_row_type    dir_rows [N_DIRECTED];

   int mismatches;
   int items_sent;
   bit steady;   // no idling on either side while set

   function automatic int draw_wait();
      return steady ? 0 : int'($urandom_range(0, 9));
   endfunction

   // ---------------------------------------------------------------------
   // escaper model
   // ---------------------------------------------------------------------
   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h41 + 8'(v) - 8'd10);
   endfunction

   task automatic put_unit(input logic [15:0] unit);
      esc_bytes.push_back(CH_BSLASH);
      esc_bytes.push_back(CH_U);
      for (int i = 3; i >= 0; i--)
         esc_bytes.push_back(hex_digit(unit[i*4 +: 4]));
   endtask

   task automatic put_ascii(input logic [7:0] b);
      logic [7:0] short_esc;
      case (b)
         8'h22:   short_esc = CH_QUOTE;
         8'h5C:   short_esc = CH_BSLASH;
         8'h08:   short_esc = 8'h62;   // b
         8'h09:   short_esc = 8'h74;   // t
         8'h0A:   short_esc = 8'h6E;   // n
         8'h0C:   short_esc = 8'h66;   // f
         8'h0D:   short_esc = 8'h72;   // r
         default: short_esc = 8'h00;
      endcase
      if (short_esc != 8'h00) begin
         esc_bytes.push_back(CH_BSLASH);
         esc_bytes.push_back(short_esc);
      end else if (b < 8'h20) begin
         put_unit({8'h00, b});
      end else begin
         esc_bytes.push_back(b);
      end
   endtask

   task automatic flush_held();
      for (int i = 0; i < held_n; i++)
         put_unit(UNIT_BAD);
      held_n  = 0;
      seq_len = 0;
   endtask

   // byte seen with nothing held
   task automatic start_seq(input logic [7:0] b);
      int len;
      len = 0;
      if (b < 8'h80) begin
         put_ascii(b);
      end else begin
         if (b >= 8'hC2 && b <= 8'hDF)      len = 2;
         else if (b >= 8'hE0 && b <= 8'hEF) len = 3;
         else if (b >= 8'hF0 && b <= 8'hF4) len = 4;
         if (len == 0) begin
            put_unit(UNIT_BAD);
         end else begin
            held_b[0] = b;
            held_n    = 1;
            seq_len   = len;
         end
      end
   endtask

   // second byte ranges narrow for E0, ED, F0 and F4 leads
   function automatic bit cont_ok(input logic [7:0] lead, input int pos,
                                  input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (pos == 1) begin
         if (lead == 8'hE0)      lo = 8'hA0;
         else if (lead == 8'hED) hi = 8'h9F;
         else if (lead == 8'hF0) lo = 8'h90;
         else if (lead == 8'hF4) hi = 8'h8F;
      end
      return (b >= lo) && (b <= hi);
   endfunction

   task automatic finish_seq(input logic [7:0] b);
      logic [20:0] cp;
      logic [19:0] off;
      if (seq_len == 4) begin
         cp  = {held_b[0][2:0], held_b[1][5:0], held_b[2][5:0], b[5:0]};
         off = 20'(cp - 21'h10000);
         put_unit(16'hD800 + {6'd0, off[19:10]});
         put_unit(16'hDC00 + {6'd0, off[9:0]});
      end else begin
         for (int i = 0; i < held_n; i++)
            esc_bytes.push_back(held_b[i]);
         esc_bytes.push_back(b);
      end
      held_n  = 0;
      seq_len = 0;
   endtask

   // escaped bytes caused by one accepted input byte, left in esc_bytes
   task automatic escape_byte(input logic [7:0] b, input logic last);
      esc_bytes.delete();
      if (held_n != 0) begin
         if (held_n < seq_len && cont_ok(held_b[0], held_n, b)) begin
            if (held_n + 1 == seq_len) begin
               finish_seq(b);
            end else if (held_n < 3) begin
               held_b[held_n] = b;
               held_n++;
            end else begin
               flush_held();
               start_seq(b);
            end
         end else begin
            flush_held();
            start_seq(b);
         end
      end else begin
         start_seq(b);
      end
      if (last && held_n != 0)
         flush_held();
   endtask

   // ---------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------
   // entered at a falling edge, returns at the falling edge after the accept
   task automatic push_byte(input logic [7:0] b, input logic last, input string want);
      int             gap;
      esc_result_type r;
      gap = draw_wait();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      do @(posedge clock); while (!req_chan.ready);
      // accepted at this edge: queue what it should produce
      escape_byte(b, last);
      if (want.len() != 0) begin
         esc_bytes.delete();
         for (int i = 0; i < want.len(); i++)
            esc_bytes.push_back(want[i]);
      end
      foreach (esc_bytes[k]) begin
         r.out_byte   = esc_bytes[k];
         r.run_end    = (k == esc_bytes.size() - 1);
         r.string_end = (k == esc_bytes.size() - 1) && last;
         escaped_q.push_back(r);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // hold the input off until every queued byte has come out
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (escaped_q.size() != 0) @(negedge clock);
   endtask

   // well-formed sequence of len bytes, of which the first keep are queued
   task automatic add_multibyte(input int len, input int keep);
      logic [7:0] s [0:3];
      logic [7:0] lo;
      logic [7:0] hi;
      case (len)
         2:       s[0] = 8'($urandom_range(8'hC2, 8'hDF));
         3:       s[0] = 8'($urandom_range(8'hE0, 8'hEF));
         default: s[0] = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      lo = 8'h80;
      hi = 8'hBF;
      if (s[0] == 8'hE0)      lo = 8'hA0;
      else if (s[0] == 8'hED) hi = 8'h9F;
      else if (s[0] == 8'hF0) lo = 8'h90;
      else if (s[0] == 8'hF4) hi = 8'h8F;
      s[1] = 8'($urandom_range(lo, hi));
      s[2] = 8'($urandom_range(8'h80, 8'hBF));
      s[3] = 8'($urandom_range(8'h80, 8'hBF));
      for (int i = 0; i < keep; i++)
         str_bytes.push_back(s[i]);
   endtask

   task automatic add_char();
      int       len;
      int       w;
      pick_type pick;
      logic [7:0] lead;
      w = $urandom_range(0, 99);
      if (w < 45)      pick = PICK_ASCII;
      else if (w < 60) pick = PICK_TWO;
      else if (w < 73) pick = PICK_THREE;
      else if (w < 85) pick = PICK_FOUR;
      else if (w < 89) pick = PICK_NOISE;
      else if (w < 93) pick = PICK_TRUNC;
      else if (w < 97) pick = PICK_BREAK;
      else             pick = PICK_EDGE;
      case (pick)
         PICK_ASCII: str_bytes.push_back(8'($urandom_range(0, 127)));
         PICK_TWO:   add_multibyte(2, 2);
         PICK_THREE: add_multibyte(3, 3);
         PICK_FOUR:  add_multibyte(4, 4);
         PICK_NOISE: str_bytes.push_back(8'($urandom_range(0, 255)));
         PICK_TRUNC: begin
            // prefix only; what follows or the string end breaks it
            len = $urandom_range(2, 4);
            add_multibyte(len, $urandom_range(1, len - 1));
         end
         PICK_BREAK: begin
            len = $urandom_range(2, 4);
            add_multibyte(len, $urandom_range(1, len - 1));
            if ($urandom_range(0, 1) == 0)
               str_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            else
               str_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         end
         default: begin
            // second byte just outside the narrowed range of its lead
            case ($urandom_range(0, 3))
               0:       lead = 8'hE0;
               1:       lead = 8'hED;
               2:       lead = 8'hF0;
               default: lead = 8'hF4;
            endcase
            str_bytes.push_back(lead);
            case (lead)
               8'hE0:   str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
               8'hED:   str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
               8'hF0:   str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
               default: str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
            endcase
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      int n_chars;
      bit drained_mid;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.in_last = 1'b0;
      held_n           = 0;
      seq_len          = 0;
      mismatches       = 0;
      items_sent       = 0;
      steady           = 1'b0;
      drained_mid      = 1'b0;

      dir_rows = '{
         '{8'h00, 1'b0, "\\u0000"},
         '{8'h1F, 1'b0, "\\u001F"},
         '{8'h22, 1'b0, "\\\""},
         '{8'h5C, 1'b0, "\\\\"},
         '{8'h08, 1'b0, "\\b"},
         '{8'h09, 1'b0, "\\t"},
         '{8'h0A, 1'b0, "\\n"},
         '{8'h0C, 1'b0, "\\f"},
         '{8'h0D, 1'b0, "\\r"},
         '{8'h41, 1'b0, "A"},
         '{8'h7F, 1'b0, ""},
         '{8'h80, 1'b0, "\\uFFFD"},
         '{8'hC1, 1'b0, "\\uFFFD"},
         '{8'hF5, 1'b0, "\\uFFFD"},
         '{8'hFF, 1'b1, "\\uFFFD"},
         // two-byte sequence at its low end
         '{8'hC2, 1'b0, ""},
         '{8'h80, 1'b0, ""},
         // highest code point, surrogate pair out
         '{8'hF4, 1'b0, ""},
         '{8'h8F, 1'b0, ""},
         '{8'hBF, 1'b0, ""},
         '{8'hBF, 1'b0, ""},
         // E0 followed by a byte below its range: lead flushed as FFFD, 80 is a bad lead
         '{8'hE0, 1'b0, ""},
         '{8'h80, 1'b0, "\\uFFFD\\uFFFD"},
         // sequence cut off by the string end
         '{8'hF0, 1'b0, ""},
         '{8'h90, 1'b1, "\\uFFFD\\uFFFD"}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         push_byte(dir_rows[i].in_byte, dir_rows[i].in_last, dir_rows[i].want);

      drain();

      // random strings, now and then with no idling at all
      while (items_sent < N_DIRECTED + N_RANDOM) begin
         steady = ($urandom_range(0, 3) == 0);
         str_bytes.delete();
         n_chars = $urandom_range(1, 10);
         repeat (n_chars) add_char();
         foreach (str_bytes[i])
            push_byte(str_bytes[i], i == str_bytes.size() - 1, "");
         if (!drained_mid && items_sent > N_DIRECTED + N_RANDOM / 2) begin
            drained_mid = 1'b1;
            drain();
         end
      end
      steady = 1'b0;

      drain();
      repeat (SETTLE_TICKS) @(negedge clock);

      if (mismatches == 0)
         $display("[utf8_to_json_escaped_stream_core] OK");
      else
         $display("[utf8_to_json_escaped_stream_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // result side: random back-pressure and in-order checking
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      esc_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (escaped_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got byte %02h",
                     $time, rsp_chan.out_byte);
         end else begin
            exp_r = escaped_q.pop_front();
            if (rsp_chan.out_byte !== exp_r.out_byte) begin
               mismatches++;
               $display("%0t: out_byte expected %02h, got %02h",
                        $time, exp_r.out_byte, rsp_chan.out_byte);
            end
            if (rsp_chan.run_end !== exp_r.run_end) begin
               mismatches++;
               $display("%0t: run_end expected %0b, got %0b",
                        $time, exp_r.run_end, rsp_chan.run_end);
            end
            if (rsp_chan.string_end !== exp_r.string_end) begin
               mismatches++;
               $display("%0t: string_end expected %0b, got %0b",
                        $time, exp_r.string_end, rsp_chan.string_end);
            end
         end
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("[utf8_to_json_escaped_stream_core] ERROR");
      $finish;
   end

endmodule
